// ===== sv/bfdg_pkg.sv =====
// ----------------------------------------------------------------------------
// bfdg_pkg
// Shared constants, glyph table and helper functions of the dot generator.
// ----------------------------------------------------------------------------
`default_nettype none

package bfdg_pkg;

  localparam int unsigned MAX_SCALE     = 16;
  localparam int unsigned GLYPH_FIRST   = 32;
  localparam int unsigned GLYPH_LAST    = 95;
  localparam int unsigned LOWER_FIRST   = 97;
  localparam int unsigned LOWER_LAST    = 122;
  localparam int unsigned CASE_OFFSET   = 32;
  localparam int unsigned GLYPH_COLS    = 5;
  localparam int unsigned GLYPH_ROWS    = 7;
  localparam int unsigned ADVANCE_CELLS = 6;
  localparam int unsigned COORD_MAX     = 32767;

  localparam int unsigned SCALE_W = 5;
  localparam int unsigned COL_W   = 3;
  localparam int unsigned ROW_W   = 3;
  // offsets reach (GLYPH_ROWS-1)*MAX_SCALE and ADVANCE_CELLS*MAX_SCALE
  localparam int unsigned OFF_W   = 7;
  // one byte per column, row 7 always dark
  localparam int unsigned GLYPH_W = 8 * GLYPH_COLS;

  localparam logic [COL_W-1:0] LAST_COL = COL_W'(GLYPH_COLS - 1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(GLYPH_ROWS - 1);

  typedef struct packed {
    logic load;
    logic step;
  } cmd_t;

  typedef struct packed {
    logic stall;
    logic last_pos;
  } stat_t;

  // fold lower case, map unknown codes to space, return glyph index
  function automatic logic [5:0] fold_char(input logic [7:0] code);
    logic [7:0] c;
    c = code;
    if (c >= 8'(LOWER_FIRST) && c <= 8'(LOWER_LAST)) begin
      c = c - 8'(CASE_OFFSET);
    end
    if (c < 8'(GLYPH_FIRST) || c > 8'(GLYPH_LAST)) begin
      c = 8'(GLYPH_FIRST);
    end
    return 6'(c - 8'(GLYPH_FIRST));
  endfunction

  // column c occupies bits [8c+7:8c], bit 8c+r is row r
  function automatic logic [GLYPH_W-1:0] glyph_word(input logic [5:0] idx);
    logic [GLYPH_W-1:0] w;
    case (idx)
      6'd0:    w = 40'h0000000000;
      6'd1:    w = 40'h00005F0000;
      6'd2:    w = 40'h0007000700;
      6'd3:    w = 40'h147F147F14;
      6'd4:    w = 40'h122A7F2A24;
      6'd5:    w = 40'h6264081323;
      6'd6:    w = 40'h5022554936;
      6'd7:    w = 40'h0000030500;
      6'd8:    w = 40'h0041221C00;
      6'd9:    w = 40'h001C224100;
      6'd10:   w = 40'h14083E0814;
      6'd11:   w = 40'h08083E0808;
      6'd12:   w = 40'h0000305000;
      6'd13:   w = 40'h0808080808;
      6'd14:   w = 40'h0000606000;
      6'd15:   w = 40'h0204081020;
      6'd16:   w = 40'h3E4549513E;
      6'd17:   w = 40'h00407F4200;
      6'd18:   w = 40'h4649516142;
      6'd19:   w = 40'h314B454121;
      6'd20:   w = 40'h107F121418;
      6'd21:   w = 40'h3945454527;
      6'd22:   w = 40'h3049494A3C;
      6'd23:   w = 40'h0305097101;
      6'd24:   w = 40'h3649494936;
      6'd25:   w = 40'h1E29494906;
      6'd26:   w = 40'h0000363600;
      6'd27:   w = 40'h0000365600;
      6'd28:   w = 40'h0041221408;
      6'd29:   w = 40'h1414141414;
      6'd30:   w = 40'h0814224100;
      6'd31:   w = 40'h0609510102;
      6'd32:   w = 40'h3E41794932;
      6'd33:   w = 40'h7E1111117E;
      6'd34:   w = 40'h364949497F;
      6'd35:   w = 40'h224141413E;
      6'd36:   w = 40'h1C2241417F;
      6'd37:   w = 40'h414949497F;
      6'd38:   w = 40'h010909097F;
      6'd39:   w = 40'h7A4949413E;
      6'd40:   w = 40'h7F0808087F;
      6'd41:   w = 40'h00417F4100;
      6'd42:   w = 40'h013F414020;
      6'd43:   w = 40'h412214087F;
      6'd44:   w = 40'h404040407F;
      6'd45:   w = 40'h7F020C027F;
      6'd46:   w = 40'h7F1008047F;
      6'd47:   w = 40'h3E4141413E;
      6'd48:   w = 40'h060909097F;
      6'd49:   w = 40'h5E2151413E;
      6'd50:   w = 40'h462919097F;
      6'd51:   w = 40'h3149494946;
      6'd52:   w = 40'h01017F0101;
      6'd53:   w = 40'h3F4040403F;
      6'd54:   w = 40'h1F2040201F;
      6'd55:   w = 40'h3F4038403F;
      6'd56:   w = 40'h6314081463;
      6'd57:   w = 40'h0708700807;
      6'd58:   w = 40'h4345495161;
      6'd59:   w = 40'h0041417F00;
      6'd60:   w = 40'h2010080402;
      6'd61:   w = 40'h007F414100;
      6'd62:   w = 40'h0402010204;
      6'd63:   w = 40'h4040404040;
      default: w = '0;
    endcase
    return w;
  endfunction

  // signed coordinate plus a small positive offset, saturated at the top
  function automatic logic signed [15:0] sat_add(input logic signed [15:0] a,
                                                 input logic [OFF_W-1:0] b);
    logic signed [16:0] s;
    s = 17'(a) + $signed({10'd0, b});
    if (s > $signed(17'(COORD_MAX))) begin
      return 16'(COORD_MAX);
    end
    return s[15:0];
  endfunction

endpackage

`default_nettype wire

// ===== sv/bfdg_in_if.sv =====
// ----------------------------------------------------------------------------
// bfdg_in_if
// Character channel: one word is one character with its drawing context.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfdg_in_if;
  logic               valid;
  logic               ready;
  logic [7:0]         char_code;
  logic               new_string;
  logic signed [15:0] start_x;
  logic signed [15:0] origin_y;
  logic [4:0]         dot_scale;
  logic [31:0]        text_colour;

  modport source (output valid, char_code, new_string, start_x, origin_y,
                  dot_scale, text_colour, input ready);
  modport sink   (input valid, char_code, new_string, start_x, origin_y,
                  dot_scale, text_colour, output ready);
endinterface

`default_nettype wire

// ===== sv/bfdg_out_if.sv =====
// ----------------------------------------------------------------------------
// bfdg_out_if
// Fill command channel: one word is one square to fill.
// ----------------------------------------------------------------------------
`default_nettype none

interface bfdg_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] rect_x;
  logic signed [15:0] rect_y;
  logic [4:0]         rect_size;
  logic [31:0]        fill_colour;
  logic               last_dot;

  modport source (output valid, rect_x, rect_y, rect_size, fill_colour,
                  last_dot, input ready);
  modport sink   (input valid, rect_x, rect_y, rect_size, fill_colour,
                  last_dot, output ready);
endinterface

`default_nettype wire

// ===== sv/bitmap_font_dot_generator.sv =====
// ----------------------------------------------------------------------------
// bitmap_font_dot_generator
// 5x7 font character generator: one fill command word per lit dot.
// ----------------------------------------------------------------------------
//   channel  dir  word
//   in_i     in   character, new_string, start_x, origin_y, scale, colour
//   out_o    out  square x, y, size, colour, last_dot flag
//
// a character is taken, then the 35 dot positions are scanned one per cycle
// while out_o does not stall.
// the scan pauses while a lit-dot word waits in the output register.
// the next character is taken while the last word of a character still waits.
// reset clears the cursor to zero and empties the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bitmap_font_dot_generator (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  bfdg_in_if.sink    in_i,
  bfdg_out_if.source out_o
);
  import bfdg_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  bfdg_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  bfdg_dpath u_dpath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .char_code_i   (in_i.char_code),
    .new_string_i  (in_i.new_string),
    .start_x_i     (in_i.start_x),
    .origin_y_i    (in_i.origin_y),
    .dot_scale_i   (in_i.dot_scale),
    .text_colour_i (in_i.text_colour),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .rect_x_o      (out_o.rect_x),
    .rect_y_o      (out_o.rect_y),
    .rect_size_o   (out_o.rect_size),
    .fill_colour_o (out_o.fill_colour),
    .last_dot_o    (out_o.last_dot)
  );

endmodule

`default_nettype wire

// ===== sv/bfdg_ctrl.sv =====
// ----------------------------------------------------------------------------
// bfdg_ctrl
// Controller: takes a character, then steps the datapath over all 35 dots.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdg_ctrl (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           in_valid_i,
  output logic                in_ready_o,
  input  wire bfdg_pkg::stat_t stat_i,
  output bfdg_pkg::cmd_t      cmd_o
);
  import bfdg_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_SCAN = 2'b10
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!stat_i.stall) begin
          cmd_o.step = 1'b1;
          if (stat_i.last_pos) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/bfdg_dpath.sv =====
// ----------------------------------------------------------------------------
// bfdg_dpath
// Datapath: glyph latch, dot scan counters, offsets, cursor, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module bfdg_dpath (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire bfdg_pkg::cmd_t     cmd_i,
  output bfdg_pkg::stat_t         stat_o,
  input  wire logic [7:0]         char_code_i,
  input  wire logic               new_string_i,
  input  wire logic signed [15:0] start_x_i,
  input  wire logic signed [15:0] origin_y_i,
  input  wire logic [4:0]         dot_scale_i,
  input  wire logic [31:0]        text_colour_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic signed [15:0]      rect_x_o,
  output logic signed [15:0]      rect_y_o,
  output logic [4:0]              rect_size_o,
  output logic [31:0]             fill_colour_o,
  output logic                    last_dot_o
);
  import bfdg_pkg::*;

  logic [GLYPH_W-1:0]  glyph_q;
  logic [COL_W-1:0]    col_q;
  logic [ROW_W-1:0]    row_q;
  logic [OFF_W-1:0]    col_off_q, row_off_q;
  logic signed [15:0]  cursor_q, oy_q;
  logic [SCALE_W-1:0]  scale_q, scale_in;
  logic [31:0]         colour_q;
  logic                out_valid_q;

  logic [5:0]          pos;
  logic [GLYPH_W-1:0]  rest;
  logic                dot_lit, last_pos, more_dots;
  logic [OFF_W-1:0]    advance;

  always_comb begin
    scale_in = dot_scale_i;
    if (dot_scale_i == '0) begin
      scale_in = SCALE_W'(1);
    end else if (dot_scale_i > SCALE_W'(MAX_SCALE)) begin
      scale_in = SCALE_W'(MAX_SCALE);
    end
  end

  assign pos       = {col_q, row_q};
  assign dot_lit   = glyph_q[pos];
  assign rest      = glyph_q >> pos;
  assign more_dots = |rest[GLYPH_W-1:1];
  assign last_pos  = (col_q == LAST_COL) && (row_q == LAST_ROW);
  assign advance   = OFF_W'(ADVANCE_CELLS) * OFF_W'(scale_q);

  assign stat_o.stall    = out_valid_q && !out_ready_i;
  assign stat_o.last_pos = last_pos;
  assign out_valid_o     = out_valid_q;

  // glyph and context latch, scan position and offsets
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      glyph_q   <= glyph_word(fold_char(char_code_i));
      col_q     <= '0;
      row_q     <= '0;
      col_off_q <= '0;
      row_off_q <= '0;
      oy_q      <= origin_y_i;
      scale_q   <= scale_in;
      colour_q  <= text_colour_i;
    end else if (cmd_i.step) begin
      if (row_q == LAST_ROW) begin
        row_q     <= '0;
        row_off_q <= '0;
        col_q     <= col_q + COL_W'(1);
        col_off_q <= col_off_q + OFF_W'(scale_q);
      end else begin
        row_q     <= row_q + ROW_W'(1);
        row_off_q <= row_off_q + OFF_W'(scale_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cursor_q <= '0;
    end else if (cmd_i.load && new_string_i) begin
      cursor_q <= start_x_i;
    end else if (cmd_i.step && last_pos) begin
      cursor_q <= sat_add(cursor_q, advance);
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.step && dot_lit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.step && dot_lit) begin
      rect_x_o      <= sat_add(cursor_q, col_off_q);
      rect_y_o      <= sat_add(oy_q, row_off_q);
      rect_size_o   <= scale_q;
      fill_colour_o <= colour_q;
      last_dot_o    <= !more_dots;
    end
  end

endmodule

`default_nettype wire

// ===== bench/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the 5x7 font dot generator. Characters go in as
// whole strings and as loose noise, with random source gaps and sink stalls;
// every fill word that comes out is compared with a local prediction of the
// lit dots, the cursor advance and the coordinate saturation.
// ----------------------------------------------------------------------------

module tb_top;
  import bfdg_pkg::*;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int MAX_IDLE    = 18;
  localparam int DRAIN_WAIT  = 40;
  localparam int RAND_CHARS  = 300;

  typedef struct packed {
    logic [7:0]         char_code;
    logic               new_string;
    logic signed [15:0] start_x;
    logic signed [15:0] origin_y;
    logic [4:0]         dot_scale;
    logic [31:0]        text_colour;
  } char_word_t;

  typedef struct packed {
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [4:0]         rect_size;
    logic [31:0]        fill_colour;
    logic               last_dot;
  } fill_word_t;

  // column-major font, bit r of a column byte is row r
  localparam logic [7:0] FONT_COLUMNS [0:319] = '{
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00,  8'h00, 8'h00, 8'h5F, 8'h00, 8'h00,
    8'h00, 8'h07, 8'h00, 8'h07, 8'h00,  8'h14, 8'h7F, 8'h14, 8'h7F, 8'h14,
    8'h24, 8'h2A, 8'h7F, 8'h2A, 8'h12,  8'h23, 8'h13, 8'h08, 8'h64, 8'h62,
    8'h36, 8'h49, 8'h55, 8'h22, 8'h50,  8'h00, 8'h05, 8'h03, 8'h00, 8'h00,
    8'h00, 8'h1C, 8'h22, 8'h41, 8'h00,  8'h00, 8'h41, 8'h22, 8'h1C, 8'h00,
    8'h14, 8'h08, 8'h3E, 8'h08, 8'h14,  8'h08, 8'h08, 8'h3E, 8'h08, 8'h08,
    8'h00, 8'h50, 8'h30, 8'h00, 8'h00,  8'h08, 8'h08, 8'h08, 8'h08, 8'h08,
    8'h00, 8'h60, 8'h60, 8'h00, 8'h00,  8'h20, 8'h10, 8'h08, 8'h04, 8'h02,
    8'h3E, 8'h51, 8'h49, 8'h45, 8'h3E,  8'h00, 8'h42, 8'h7F, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46,  8'h21, 8'h41, 8'h45, 8'h4B, 8'h31,
    8'h18, 8'h14, 8'h12, 8'h7F, 8'h10,  8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3C, 8'h4A, 8'h49, 8'h49, 8'h30,  8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36,  8'h06, 8'h49, 8'h49, 8'h29, 8'h1E,
    8'h00, 8'h36, 8'h36, 8'h00, 8'h00,  8'h00, 8'h56, 8'h36, 8'h00, 8'h00,
    8'h08, 8'h14, 8'h22, 8'h41, 8'h00,  8'h14, 8'h14, 8'h14, 8'h14, 8'h14,
    8'h00, 8'h41, 8'h22, 8'h14, 8'h08,  8'h02, 8'h01, 8'h51, 8'h09, 8'h06,
    8'h32, 8'h49, 8'h79, 8'h41, 8'h3E,  8'h7E, 8'h11, 8'h11, 8'h11, 8'h7E,
    8'h7F, 8'h49, 8'h49, 8'h49, 8'h36,  8'h3E, 8'h41, 8'h41, 8'h41, 8'h22,
    8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C,  8'h7F, 8'h49, 8'h49, 8'h49, 8'h41,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h01,  8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A,
    8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F,  8'h00, 8'h41, 8'h7F, 8'h41, 8'h00,
    8'h20, 8'h40, 8'h41, 8'h3F, 8'h01,  8'h7F, 8'h08, 8'h14, 8'h22, 8'h41,
    8'h7F, 8'h40, 8'h40, 8'h40, 8'h40,  8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F,
    8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F,  8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E,
    8'h7F, 8'h09, 8'h09, 8'h09, 8'h06,  8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E,
    8'h7F, 8'h09, 8'h19, 8'h29, 8'h46,  8'h46, 8'h49, 8'h49, 8'h49, 8'h31,
    8'h01, 8'h01, 8'h7F, 8'h01, 8'h01,  8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F,
    8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F,  8'h3F, 8'h40, 8'h38, 8'h40, 8'h3F,
    8'h63, 8'h14, 8'h08, 8'h14, 8'h63,  8'h07, 8'h08, 8'h70, 8'h08, 8'h07,
    8'h61, 8'h51, 8'h49, 8'h45, 8'h43,  8'h00, 8'h7F, 8'h41, 8'h41, 8'h00,
    8'h02, 8'h04, 8'h08, 8'h10, 8'h20,  8'h00, 8'h41, 8'h41, 8'h7F, 8'h00,
    8'h04, 8'h02, 8'h01, 8'h02, 8'h04,  8'h40, 8'h40, 8'h40, 8'h40, 8'h40
  };

  logic       clk_i  = 1'b0;
  logic       rst_ni = 1'b0;
  logic       char_valid = 1'b0;
  char_word_t char_held  = '0;
  logic       fill_ready = 1'b0;

  bfdg_in_if  char_if ();
  bfdg_out_if fill_if ();

  assign char_if.valid       = char_valid;
  assign char_if.char_code   = char_held.char_code;
  assign char_if.new_string  = char_held.new_string;
  assign char_if.start_x     = char_held.start_x;
  assign char_if.origin_y    = char_held.origin_y;
  assign char_if.dot_scale   = char_held.dot_scale;
  assign char_if.text_colour = char_held.text_colour;
  assign fill_if.ready       = fill_ready;

  bitmap_font_dot_generator u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (char_if),
    .out_o  (fill_if)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  char_word_t         text_queue[$];
  fill_word_t         pending_fills[$];
  logic signed [15:0] pen_x;
  int                 chars_sent;
  int                 chars_taken;
  int                 dots_seen;
  int                 char_gap;
  int                 fill_stall;
  int                 mismatches;
  int                 cycle_count;

  function automatic int clamp_coord(input int v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return v;
  endfunction

  // every third stretch of 48 words runs with no idling
  function automatic int draw_idle(input int count);
    if ((count / 48) % 3 == 0) return 0;
    return $urandom_range(0, MAX_IDLE);
  endfunction

  function automatic int draw_scale();
    if ($urandom_range(0, 9) != 0) return $urandom_range(1, 16);
    if ($urandom_range(0, 1) != 0) return 0;
    return $urandom_range(17, 31);
  endfunction

  // work out the fill words of one taken character and move the pen
  function automatic void expand_glyph(input char_word_t w);
    int         scale;
    int         code;
    int         col;
    int         row;
    int         n;
    logic [7:0] column;
    fill_word_t dots [35];
    scale = int'(w.dot_scale);
    if (scale < 1) scale = 1;
    if (scale > int'(MAX_SCALE)) scale = int'(MAX_SCALE);
    if (w.new_string) pen_x = w.start_x;
    code = int'(w.char_code);
    if (code >= int'(LOWER_FIRST) && code <= int'(LOWER_LAST)) begin
      code = code - int'(CASE_OFFSET);
    end
    if (code < int'(GLYPH_FIRST) || code > int'(GLYPH_LAST)) code = int'(GLYPH_FIRST);
    n = 0;
    for (col = 0; col < 5; col++) begin
      column = FONT_COLUMNS[(code - int'(GLYPH_FIRST)) * 5 + col];
      for (row = 0; row < 7; row++) begin
        if (column[row]) begin
          dots[n].rect_x      = 16'(clamp_coord(int'(pen_x) + col * scale));
          dots[n].rect_y      = 16'(clamp_coord(int'(w.origin_y) + row * scale));
          dots[n].rect_size   = 5'(scale);
          dots[n].fill_colour = w.text_colour;
          dots[n].last_dot    = 1'b0;
          n++;
        end
      end
    end
    for (col = 0; col < n; col++) begin
      dots[col].last_dot = (col == n - 1);
      pending_fills.push_back(dots[col]);
    end
    pen_x = 16'(clamp_coord(int'(pen_x) + 6 * scale));
  endfunction

  function automatic void check_field(input string name, input longint want,
                                      input longint got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  task automatic queue_char(input logic [7:0] c, input logic fresh, input int sx,
                            input int oy, input int sc, input logic [31:0] colour);
    char_word_t w;
    w.char_code   = c;
    w.new_string  = fresh;
    w.start_x     = 16'(sx);
    w.origin_y    = 16'(oy);
    w.dot_scale   = 5'(sc);
    w.text_colour = colour;
    text_queue.push_back(w);
  endtask

  // character source
  always @(posedge clk_i or negedge rst_ni) begin : drive_chars
    bit busy;
    if (!rst_ni) begin
      char_valid  <= 1'b0;
      char_gap    <= 0;
      chars_sent  <= 0;
      chars_taken <= 0;
      pen_x       = '0;
    end else begin
      busy = char_valid && !char_if.ready;
      if (char_valid && char_if.ready) begin
        expand_glyph(char_held);
        chars_taken <= chars_taken + 1;
      end
      if (!busy) begin
        if (char_gap != 0) begin
          char_gap   <= char_gap - 1;
          char_valid <= 1'b0;
        end else if (text_queue.size() != 0) begin
          char_held  <= text_queue.pop_front();
          char_valid <= 1'b1;
          char_gap   <= draw_idle(chars_sent);
          chars_sent <= chars_sent + 1;
        end else begin
          char_valid <= 1'b0;
        end
      end
    end
  end

  // fill word sink and checker
  always @(posedge clk_i or negedge rst_ni) begin : check_fills
    fill_word_t got;
    fill_word_t want;
    int         stall;
    if (!rst_ni) begin
      fill_ready <= 1'b0;
      fill_stall <= 0;
      dots_seen  <= 0;
    end else if (fill_if.valid && fill_ready) begin
      got.rect_x      = fill_if.rect_x;
      got.rect_y      = fill_if.rect_y;
      got.rect_size   = fill_if.rect_size;
      got.fill_colour = fill_if.fill_colour;
      got.last_dot    = fill_if.last_dot;
      if (pending_fills.size() == 0) begin
        $error("fill word with none pending: x=%0d y=%0d size=%0d",
               got.rect_x, got.rect_y, got.rect_size);
        mismatches++;
      end else begin
        want = pending_fills.pop_front();
        check_field("rect_x", want.rect_x, got.rect_x);
        check_field("rect_y", want.rect_y, got.rect_y);
        check_field("rect_size", want.rect_size, got.rect_size);
        check_field("fill_colour", want.fill_colour, got.fill_colour);
        check_field("last_dot", want.last_dot, got.last_dot);
      end
      stall = draw_idle(dots_seen + 24);
      dots_seen  <= dots_seen + 1;
      fill_stall <= stall;
      fill_ready <= (stall == 0);
    end else if (fill_stall != 0) begin
      fill_stall <= fill_stall - 1;
      fill_ready <= (fill_stall == 1);
    end else begin
      fill_ready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run_text
    int total;
    int placed;
    int len;
    int sx;
    int oy;
    int sc;
    int i;
    logic [31:0] colour;
    logic [7:0]  c;
    cycle_count = 0;
    mismatches  = 0;

    // directed: folding, unmapped codes, scale clamping, saturation
    queue_char(" ", 1'b1, 0, 0, 1, 32'h0000_0000);
    queue_char("A", 1'b0, 0, 0, 1, 32'hFFFF_FFFF);
    queue_char("8", 1'b0, 12345, 0, 0, 32'h1234_5678);
    queue_char("a", 1'b0, 0, 100, 16, 32'hA5A5_5A5A);
    queue_char("z", 1'b0, -1, -100, 17, 32'h5A5A_A5A5);
    queue_char("#", 1'b1, -32768, -32768, 31, 32'h8000_0001);
    queue_char(8'd96, 1'b0, 0, 0, 2, 32'h0F0F_0F0F);
    queue_char(8'd123, 1'b0, 0, 0, 2, 32'hF0F0_F0F0);
    queue_char(8'd255, 1'b0, 0, 0, 2, 32'h0000_00FF);
    queue_char(8'd0, 1'b0, 0, 0, 2, 32'hFF00_0000);
    queue_char(8'd31, 1'b0, 0, 0, 3, 32'h0000_0001);
    queue_char("_", 1'b0, 0, 7, 3, 32'h7FFF_FFFF);
    queue_char("@", 1'b1, 32767, 32767, 16, 32'hDEAD_BEEF);
    queue_char("M", 1'b0, 0, 32700, 16, 32'h0101_0101);
    queue_char("!", 1'b1, 32700, 0, 16, 32'h0202_0202);
    queue_char("W", 1'b0, -32768, 0, 16, 32'h0404_0404);
    queue_char("B", 1'b1, 32600, 32600, 5, 32'h0808_0808);
    queue_char(8'd126, 1'b0, 0, 0, 1, 32'h1010_1010);
    queue_char("0", 1'b1, 100, 50, 2, 32'h2020_2020);
    queue_char("9", 1'b0, 555, 50, 2, 32'h4040_4040);
    queue_char(" ", 1'b0, 0, 50, 2, 32'h8080_8080);
    queue_char("Z", 1'b0, 0, 50, 2, 32'hC3C3_C3C3);
    queue_char("m", 1'b1, -50, -3, 3, 32'h3C3C_3C3C);
    queue_char("^", 1'b0, 0, -32768, 8, 32'h0000_FFFF);

    // random: mostly whole strings, some loose noise words
    placed = 0;
    while (placed < RAND_CHARS) begin
      if ($urandom_range(0, 9) < 8) begin
        len    = $urandom_range(1, 12);
        sx     = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 2000) - 300;
        oy     = ($urandom_range(0, 7) == 0) ? int'($urandom) : $urandom_range(0, 2000) - 300;
        sc     = draw_scale();
        colour = $urandom;
        for (i = 0; i < len; i++) begin
          c = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(97, 122))
                                          : 8'($urandom_range(32, 95));
          // start_x only counts on the first word of a string
          queue_char(c, (i == 0), (i == 0) ? sx : int'($urandom), oy, sc, colour);
        end
        placed += len;
      end else begin
        queue_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), int'($urandom),
                   int'($urandom), $urandom_range(0, 31), $urandom);
        placed++;
      end
    end
    total = text_queue.size();

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (chars_taken != total || pending_fills.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
